/* design/ffa_pkg.sv */
package ffa_pkg;

	// Sizes of the tables and of the address space.
	localparam int ADDR_W = 16;
	localparam int MAX_EXTENTS = 16;
	localparam int MAX_RECORDS = 16;
	localparam int HEADER_BYTES = 8;
	localparam int MIN_FREE_BYTES = 8;

	// Derived widths.
	localparam int EXT_IW = $clog2(MAX_EXTENTS);
	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	localparam int REC_IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int REC_CW = $clog2(MAX_RECORDS + 1);
	localparam int WIDE_W = ADDR_W + 2;
	localparam int CFG_IDX_W = 1;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	// Status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NO_FIT = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 1'b1;

	typedef struct packed {
		logic command;
		logic [15:0] request_size;
		logic [15:0] alignment;
		logic [15:0] free_address;
	} request_t;

	typedef struct packed {
		logic [15:0] payload_address;
		logic [2:0] status;
	} response_t;

	typedef struct packed {
		logic [15:0] base;
		logic [15:0] length;
	} heap_cfg_t;

	// One free extent.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} ext_t;

	// One allocation record.
	typedef struct packed {
		logic [ADDR_W-1:0] payload;
		logic [ADDR_W-1:0] length;
		logic [ADDR_W-1:0] offset;
	} rec_t;

	typedef struct packed {
		logic we;
		logic [EXT_IW-1:0] waddr;
		ext_t wdata;
		logic [EXT_IW-1:0] raddr;
	} ext_port_t;

	typedef struct packed {
		logic we;
		logic [REC_IW-1:0] waddr;
		rec_t wdata;
		logic [REC_IW-1:0] raddr;
	} rec_port_t;

endpackage

/* design/ffa_ram.sv */
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/ffa_ctrl.sv */
module ffa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ffa_pkg::request_t request,
	output logic busy,
	output logic done,
	output ffa_pkg::response_t response,
	input logic setup_req,
	input ffa_pkg::heap_cfg_t heap_cfg,
	output ffa_pkg::ext_port_t ext_port,
	input ffa_pkg::ext_t ext_rdata,
	output ffa_pkg::rec_port_t rec_port,
	input ffa_pkg::rec_t rec_rdata
);
	import ffa_pkg::*;

	typedef enum logic [13:0] {
		S_SETUP = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_A_RD  = 14'b00000000000100,
		S_A_MEM = 14'b00000000001000,
		S_A_CHK = 14'b00000000010000,
		S_F_RRD = 14'b00000000100000,
		S_F_REV = 14'b00000001000000,
		S_F_ERD = 14'b00000010000000,
		S_F_EEV = 14'b00000100000000,
		S_F_DEC = 14'b00001000000000,
		S_SH_RD = 14'b00010000000000,
		S_SH_WR = 14'b00100000000000,
		S_WR0   = 14'b01000000000000,
		S_WR1   = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic fin_q;
	request_t req_q;
	logic [CNT_W-1:0] cnt_q, cnt_next_q, k_q, c_q, e_q;
	logic up_q;
	logic [ADDR_W-1:0] s_q, l_q, prev_s_q, prev_l_q, bs_q, bl_q;
	logic [ADDR_W:0] prev_end_q;
	logic [WIDE_W-1:0] mem_q;
	logic at_end_q;
	logic [REC_CW-1:0] r_q;
	logic [REC_IW-1:0] rhit_q, rfree_q;
	logic [MAX_RECORDS-1:0] valid_q;
	logic wr0_v_q, wr1_v_q;
	logic [EXT_IW-1:0] wr0_a_q, wr1_a_q;
	ext_t wr0_d_q, wr1_d_q;
	rec_t rec_new_q;
	logic commit_q;
	logic [2:0] status_q;
	logic [ADDR_W-1:0] addr_q;
	logic done_q;
	response_t resp_q;

	// Heap window after clipping to the address space.
	logic [ADDR_W:0] room;
	logic [ADDR_W-1:0] clip_len;
	assign room = (ADDR_W+1)'(1 << ADDR_W) - {1'b0, heap_cfg.base};
	assign clip_len = ({1'b0, heap_cfg.length} > room) ? room[ADDR_W-1:0] : heap_cfg.length;

	// Request checks.
	logic [15:0] align_m1;
	logic req_invalid;
	assign align_m1 = request.alignment - 16'd1;
	assign req_invalid = (request.request_size == '0) || (request.alignment == '0)
		|| ((request.alignment & align_m1) != '0);

	// First free record slot.
	logic [REC_IW-1:0] rfree;
	logic rfull;
	always_comb begin
		rfree = '0;
		rfull = 1'b1;
		for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				rfree = REC_IW'(i);
				rfull = 1'b0;
			end
		end
	end

	// Aligned payload placement inside the extent just read.
	logic [WIDE_W-1:0] mem_calc;
	assign mem_calc = ({2'b0, ext_rdata.start} + WIDE_W'(HEADER_BYTES)
		+ {2'b0, req_q.alignment} - WIDE_W'(1))
		& ~{2'b0, req_q.alignment - 16'd1};

	// Fit test and split of the chosen extent.
	logic [WIDE_W-1:0] off, after, lead;
	logic fit, ka, kb, mp_a, kbn;
	logic [CNT_W:0] newcount;
	assign off = mem_q - {2'b0, s_q};
	assign fit = (off <= {2'b0, l_q}) && (({2'b0, l_q} - off) >= {2'b0, req_q.request_size});
	assign after = {2'b0, s_q} + {2'b0, l_q} - mem_q - {2'b0, req_q.request_size};
	assign lead = off - WIDE_W'(HEADER_BYTES);
	assign ka = after >= WIDE_W'(MIN_FREE_BYTES);
	assign kb = lead >= WIDE_W'(MIN_FREE_BYTES);
	assign mp_a = kb && (k_q != '0) && (prev_end_q == {1'b0, s_q});
	assign kbn = kb && !mp_a;
	assign newcount = {1'b0, cnt_q} + (CNT_W+1)'(ka) + (CNT_W+1)'(kbn) - (CNT_W+1)'(1);

	// Neighbour tests for a block being freed.
	logic mp_f, mn_f;
	logic [ADDR_W:0] blk_end;
	assign blk_end = {1'b0, bs_q} + {1'b0, bl_q};
	assign mp_f = (k_q != '0) && (prev_end_q == {1'b0, bs_q});
	assign mn_f = !at_end_q && (blk_end == {1'b0, s_q});

	logic [CNT_W-1:0] k_p1, k_m1, cnt_m1, sh_waddr;
	assign k_p1 = k_q + CNT_W'(1);
	assign k_m1 = k_q - CNT_W'(1);
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign sh_waddr = up_q ? (c_q + CNT_W'(1)) : (c_q - CNT_W'(1));

	// Memory port drive.
	always_comb begin
		ext_port = '0;
		rec_port = '0;
		case (state_q)
			S_SETUP: begin
				ext_port.we = 1'b1;
				ext_port.wdata = '{start: heap_cfg.base, length: clip_len};
			end
			S_A_RD, S_F_ERD: ext_port.raddr = k_q[EXT_IW-1:0];
			S_SH_RD: ext_port.raddr = c_q[EXT_IW-1:0];
			S_SH_WR: begin
				ext_port.we = 1'b1;
				ext_port.waddr = sh_waddr[EXT_IW-1:0];
				ext_port.wdata = ext_rdata;
			end
			S_WR0: begin
				ext_port.we = wr0_v_q;
				ext_port.waddr = wr0_a_q;
				ext_port.wdata = wr0_d_q;
			end
			S_WR1: begin
				ext_port.we = wr1_v_q;
				ext_port.waddr = wr1_a_q;
				ext_port.wdata = wr1_d_q;
			end
			default: ext_port = '0;
		endcase
		rec_port.raddr = r_q[REC_IW-1:0];
		rec_port.waddr = rfree_q;
		rec_port.wdata = rec_new_q;
		rec_port.we = fin_q && commit_q && (req_q.command == CMD_ALLOC);
	end

	// Sequencer: scan, shift, patch and commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SETUP;
			fin_q <= 1'b0;
			cnt_q <= CNT_W'(1);
			valid_q <= '0;
			done_q <= 1'b0;
			commit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q <= 1'b0;
			if (fin_q) begin
				// Commit the new table size and record state, then report.
				done_q <= 1'b1;
				resp_q.status <= status_q;
				resp_q.payload_address <= (status_q == ST_OK) ? addr_q : '0;
				if (commit_q) begin
					cnt_q <= cnt_next_q;
					if (req_q.command == CMD_ALLOC) begin
						valid_q[rfree_q] <= 1'b1;
					end else begin
						valid_q[rhit_q] <= 1'b0;
					end
				end
				state_q <= S_IDLE;
			end else begin
				case (state_q)
					S_SETUP: begin
						cnt_q <= CNT_W'(1);
						valid_q <= '0;
						// A further register write restarts the set-up.
						if (!setup_req) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						commit_q <= 1'b0;
						addr_q <= '0;
						k_q <= '0;
						r_q <= '0;
						req_q <= request;
						if (setup_req) begin
							state_q <= S_SETUP;
						end else if (start) begin
							if (request.command == CMD_ALLOC) begin
								if (req_invalid) begin
									status_q <= ST_INVALID;
									fin_q <= 1'b1;
								end else begin
									state_q <= S_A_RD;
								end
							end else if (request.free_address == '0) begin
								status_q <= ST_OK;
								fin_q <= 1'b1;
							end else begin
								state_q <= S_F_RRD;
							end
						end
					end
					S_A_RD: begin
						if (k_q == cnt_q) begin
							status_q <= ST_NO_FIT;
							fin_q <= 1'b1;
						end else begin
							state_q <= S_A_MEM;
						end
					end
					S_A_MEM: begin
						s_q <= ext_rdata.start;
						l_q <= ext_rdata.length;
						mem_q <= mem_calc;
						state_q <= S_A_CHK;
					end
					S_A_CHK: begin
						if (!fit) begin
							prev_s_q <= s_q;
							prev_l_q <= l_q;
							prev_end_q <= {1'b0, s_q} + {1'b0, l_q};
							k_q <= k_p1;
							state_q <= S_A_RD;
						end else if ((newcount > (CNT_W+1)'(MAX_EXTENTS)) || rfull) begin
							status_q <= ST_FULL;
							fin_q <= 1'b1;
						end else begin
							status_q <= ST_OK;
							commit_q <= 1'b1;
							addr_q <= mem_q[ADDR_W-1:0];
							cnt_next_q <= newcount[CNT_W-1:0];
							rfree_q <= rfree;
							rec_new_q.payload <= mem_q[ADDR_W-1:0];
							rec_new_q.length <= req_q.request_size + ADDR_W'(HEADER_BYTES)
								+ (ka ? '0 : after[ADDR_W-1:0]);
							rec_new_q.offset <= kb ? '0 : lead[ADDR_W-1:0];
							// Gap before the payload.
							wr0_v_q <= kb;
							wr0_a_q <= mp_a ? k_m1[EXT_IW-1:0] : k_q[EXT_IW-1:0];
							wr0_d_q.start <= mp_a ? prev_s_q : s_q;
							wr0_d_q.length <= mp_a ? (prev_l_q + lead[ADDR_W-1:0])
								: lead[ADDR_W-1:0];
							// Remainder after the payload.
							wr1_v_q <= ka;
							wr1_a_q <= kbn ? k_p1[EXT_IW-1:0] : k_q[EXT_IW-1:0];
							wr1_d_q.start <= mem_q[ADDR_W-1:0] + req_q.request_size;
							wr1_d_q.length <= after[ADDR_W-1:0];
							// Entries behind the chosen one move by the size change.
							up_q <= ka && kbn;
							c_q <= (ka && kbn) ? cnt_m1 : k_p1;
							e_q <= (ka && kbn) ? k_p1 : cnt_m1;
							if ((ka != kbn) || (k_p1 >= cnt_q)) begin
								state_q <= S_WR0;
							end else begin
								state_q <= S_SH_RD;
							end
						end
					end
					S_F_RRD: begin
						if (r_q == REC_CW'(MAX_RECORDS)) begin
							status_q <= ST_UNKNOWN;
							fin_q <= 1'b1;
						end else begin
							state_q <= S_F_REV;
						end
					end
					S_F_REV: begin
						if (valid_q[r_q[REC_IW-1:0]]
							&& (rec_rdata.payload == req_q.free_address)) begin
							rhit_q <= r_q[REC_IW-1:0];
							bs_q <= rec_rdata.payload - ADDR_W'(HEADER_BYTES)
								- rec_rdata.offset;
							bl_q <= rec_rdata.length + rec_rdata.offset;
							state_q <= S_F_ERD;
						end else begin
							r_q <= r_q + REC_CW'(1);
							state_q <= S_F_RRD;
						end
					end
					S_F_ERD: begin
						if (k_q == cnt_q) begin
							at_end_q <= 1'b1;
							state_q <= S_F_DEC;
						end else begin
							state_q <= S_F_EEV;
						end
					end
					S_F_EEV: begin
						s_q <= ext_rdata.start;
						l_q <= ext_rdata.length;
						if (ext_rdata.start >= bs_q) begin
							at_end_q <= 1'b0;
							state_q <= S_F_DEC;
						end else begin
							prev_s_q <= ext_rdata.start;
							prev_l_q <= ext_rdata.length;
							prev_end_q <= {1'b0, ext_rdata.start} + {1'b0, ext_rdata.length};
							k_q <= k_p1;
							state_q <= S_F_ERD;
						end
					end
					S_F_DEC: begin
						wr1_v_q <= 1'b0;
						wr0_v_q <= 1'b1;
						up_q <= 1'b0;
						c_q <= k_p1;
						e_q <= cnt_m1;
						if (!mp_f && !mn_f && (cnt_q >= CNT_W'(MAX_EXTENTS))) begin
							status_q <= ST_FULL;
							fin_q <= 1'b1;
						end else begin
							status_q <= ST_OK;
							commit_q <= 1'b1;
							state_q <= S_WR0;
							cnt_next_q <= cnt_q;
							if (mp_f) begin
								wr0_a_q <= k_m1[EXT_IW-1:0];
								wr0_d_q.start <= prev_s_q;
								wr0_d_q.length <= mn_f ? (prev_l_q + bl_q + l_q)
									: (prev_l_q + bl_q);
								if (mn_f) begin
									cnt_next_q <= cnt_m1;
									if (k_p1 < cnt_q) begin
										state_q <= S_SH_RD;
									end
								end
							end else if (mn_f) begin
								wr0_a_q <= k_q[EXT_IW-1:0];
								wr0_d_q.start <= bs_q;
								wr0_d_q.length <= l_q + bl_q;
							end else begin
								wr0_a_q <= k_q[EXT_IW-1:0];
								wr0_d_q.start <= bs_q;
								wr0_d_q.length <= bl_q;
								cnt_next_q <= cnt_q + CNT_W'(1);
								up_q <= 1'b1;
								c_q <= cnt_m1;
								e_q <= k_q;
								if (k_q < cnt_q) begin
									state_q <= S_SH_RD;
								end
							end
						end
					end
					S_SH_RD: state_q <= S_SH_WR;
					S_SH_WR: begin
						if (c_q == e_q) begin
							state_q <= S_WR0;
						end else begin
							c_q <= up_q ? (c_q - CNT_W'(1)) : (c_q + CNT_W'(1));
							state_q <= S_SH_RD;
						end
					end
					S_WR0: state_q <= S_WR1;
					S_WR1: fin_q <= 1'b1;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE) || fin_q;
	assign done = done_q;
	assign response = resp_q;

`ifndef SYNTHESIS
	// One word per request: the result strobe is never held high.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// The extent table never grows past its capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_EXTENTS))
		else $error("extent count beyond capacity");

	// A committed allocate takes a record slot that was free.
	a_rec_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && commit_q && (req_q.command == CMD_ALLOC)) |-> !valid_q[rfree_q])
		else $error("allocation record slot already in use");

	// A failed request leaves the tables untouched.
	a_no_commit_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && (status_q != ST_OK)) |-> !commit_q)
		else $error("error status with committed change");
`endif
endmodule

/* design/first_fit_aligned_allocator_top.sv */
// Channel   | Handshake               | Word
// ----------+-------------------------+-------------------------------------
// request   | start high, busy low    | command, request_size, alignment,
//           |                         | free_address
// response  | done strobe, one cycle  | payload_address, status
// config    | cfg_we high             | cfg_index, cfg_wdata
//
// Allocate reads the extents one at a time in the first-fit scan, then shifts the table
// entries behind the chosen one and writes the split extent; free searches the records,
// then the extents, shifts entries and writes the merged or new extent.
// The single read port of the extent memory makes every scan and shift go entry by entry.
// After reset or a register write while idle, the set-up state writes the initial extent while busy is high.
// The receiver cannot stall: each result is offered for one cycle only.
module first_fit_aligned_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ffa_pkg::request_t request,
	output logic busy,
	output logic done,
	output ffa_pkg::response_t response,
	input logic cfg_we,
	input logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_wdata
);
	import ffa_pkg::*;

	heap_cfg_t cfg_q;
	ext_port_t ext_port;
	ext_t ext_rdata;
	rec_port_t rec_port;
	rec_t rec_rdata;
	logic [$bits(ext_t)-1:0] ext_rd_raw;
	logic [$bits(rec_t)-1:0] rec_rd_raw;

	// Heap window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base <= 16'd0;
			cfg_q.length <= 16'd65535;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_BASE: cfg_q.base <= cfg_wdata;
				REG_HEAP_LENGTH: cfg_q.length <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ffa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.response(response),
		.setup_req(cfg_we),
		.heap_cfg(cfg_q),
		.ext_port(ext_port),
		.ext_rdata(ext_rdata),
		.rec_port(rec_port),
		.rec_rdata(rec_rdata)
	);

	// Free extent table.
	ffa_ram #(.WIDTH($bits(ext_t)), .DEPTH(MAX_EXTENTS)) u_ext_ram (
		.clk(clk),
		.we(ext_port.we),
		.waddr(ext_port.waddr),
		.wdata(ext_port.wdata),
		.raddr(ext_port.raddr),
		.rdata(ext_rd_raw)
	);
	assign ext_rdata = ext_rd_raw;

	// Allocation record table.
	ffa_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
		.clk(clk),
		.we(rec_port.we),
		.waddr(rec_port.waddr),
		.wdata(rec_port.wdata),
		.raddr(rec_port.raddr),
		.rdata(rec_rd_raw)
	);
	assign rec_rdata = rec_rd_raw;
endmodule
